// ----- rtl/core/mzr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mzr_pkg
// Shared types and constants of the move-to-front / zero-run encoder.
// ----------------------------------------------------------------------------
package mzr_pkg;

   localparam int RUN_COUNT_BITS = 20;
   // run register holds n + 1, so it needs one extra bit
   localparam int CODE_W         = RUN_COUNT_BITS + 1;
   localparam int DIGIT_W        = $clog2(CODE_W);
   localparam int SYM_W          = 8;
   localparam int LIST_SIZE      = 256;

   typedef enum logic [1:0] {
      KIND_RUN_A = 2'd0,
      KIND_RUN_B = 2'd1,
      KIND_POS   = 2'd2,
      KIND_EOB   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_RUN,
      ST_POS,
      ST_EOB
   } state_type;

   typedef struct packed {
      logic load_item;
      logic run_incr;
      logic find_pos;
      logic emit_digit;
      logic emit_pos;
      logic emit_eob;
   } ctrl_cmd_type;

   typedef struct packed {
      logic front_hit;
      logic eob;
      logic run_pending;
      logic last_digit;
      logic out_free;
   } dp_status_type;

endpackage
`default_nettype wire

// ----- rtl/core/mzr_ifs.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mzr_ifs
// Valid/ready channels for input bytes and encoded results.
// ----------------------------------------------------------------------------
interface mzr_req_if;
   import mzr_pkg::*;

   logic             valid;
   logic             ready;
   logic [SYM_W-1:0] symbol;
   logic             end_of_block;

   modport source (output valid, output symbol, output end_of_block, input ready);
   modport sink   (input valid, input symbol, input end_of_block, output ready);
endinterface

interface mzr_rsp_if;
   import mzr_pkg::*;

   logic             valid;
   logic             ready;
   logic [1:0]       code_kind;
   logic [SYM_W-1:0] position;
   logic             last_of_run;

   modport source (output valid, output code_kind, output position, output last_of_run,
                   input ready);
   modport sink   (input valid, input code_kind, input position, input last_of_run,
                   output ready);
endinterface
`default_nettype wire

// ----- rtl/core/mtf_zero_run_encoder.sv -----
`default_nettype none
// Move-to-front encoder with zero-run coding. One byte is taken per transfer;
// a byte that repeats the front of the list gives no result unless it ends a
// block. Any other item flushes the pending run digits (up to 20), then its
// position, and the end code at block end; the sequencer sends one result per
// cycle through a single output register while the output is not stalled. The
// position comes from a parallel compare over the 256-cell list, registered
// and encoded in the next cycle. The input side is ready whenever the
// sequencer is idle, even while the last result still waits in the output
// register.
// ----------------------------------------------------------------------------
// mtf_zero_run_encoder
// Top level: sequencer plus list/run datapath on valid/ready channels.
// ----------------------------------------------------------------------------
module mtf_zero_run_encoder (
   input  logic             clock,
   input  logic             reset,
   mzr_req_if.sink          req,
   mzr_rsp_if.source        rsp
);
   import mzr_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   mzr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .status    (status),
      .cmd       (cmd)
   );

   mzr_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_symbol       (req.symbol),
      .req_end_of_block (req.end_of_block),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp.valid),
      .rsp_ready        (rsp.ready),
      .rsp_code_kind    (rsp.code_kind),
      .rsp_position     (rsp.position),
      .rsp_last_of_run  (rsp.last_of_run)
   );

endmodule
`default_nettype wire

// ----- rtl/core/mzr_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mzr_ctrl
// Sequencer: accepts a byte, then steps run digits, position and end code.
// ----------------------------------------------------------------------------
module mzr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  mzr_pkg::dp_status_type status,
   output mzr_pkg::ctrl_cmd_type  cmd
);
   import mzr_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (status.front_hit) begin
               state_in = status.eob ? ST_RUN : ST_IDLE;
            end else begin
               state_in = status.run_pending ? ST_RUN : ST_POS;
            end
         end
         ST_RUN: begin
            if (status.out_free && status.last_digit) begin
               state_in = status.front_hit ? ST_EOB : ST_POS;
            end
         end
         ST_POS: begin
            if (status.out_free) state_in = status.eob ? ST_EOB : ST_IDLE;
         end
         ST_EOB: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_item = req_valid;
         end
         ST_DECIDE: begin
            cmd.run_incr = status.front_hit;
            cmd.find_pos = !status.front_hit;
         end
         ST_RUN:  cmd.emit_digit = status.out_free;
         ST_POS:  cmd.emit_pos   = status.out_free;
         ST_EOB:  cmd.emit_eob   = status.out_free;
         default: cmd = '0;
      endcase
   end

endmodule
`default_nettype wire

// ----- rtl/core/mzr_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mzr_datapath
// Move-to-front cell row, run counter and result register.
// ----------------------------------------------------------------------------
module mzr_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [mzr_pkg::SYM_W-1:0] req_symbol,
   input  logic                      req_end_of_block,
   input  mzr_pkg::ctrl_cmd_type     cmd,
   output mzr_pkg::dp_status_type    status,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [1:0]                rsp_code_kind,
   output logic [mzr_pkg::SYM_W-1:0] rsp_position,
   output logic                      rsp_last_of_run
);
   import mzr_pkg::*;

   logic [SYM_W-1:0]     list_ff [LIST_SIZE];
   logic [LIST_SIZE-1:0] hit_ff;
   logic [LIST_SIZE-1:0] hit_in;
   logic [SYM_W-1:0]     sym_ff;
   logic                 eob_ff;
   logic [SYM_W-1:0]     pos_ff;
   logic [SYM_W-1:0]     pos_enc;

   // code_ff holds pending run + 1; digits_ff is the digit count of the run
   logic [CODE_W-1:0]    code_ff;
   logic [CODE_W-1:0]    code_inc;
   logic [DIGIT_W-1:0]   digits_ff;
   logic [DIGIT_W-1:0]   digit_idx;
   logic                 run_sat;
   logic                 code_all_ones;

   logic                 out_valid_ff;
   kind_type             kind_ff;
   logic [SYM_W-1:0]     out_pos_ff;
   logic                 out_last_ff;
   logic                 out_free;
   logic                 emit_any;

   always_comb begin
      for (int k = 0; k < LIST_SIZE; k++) begin
         hit_in[k] = (list_ff[k] == req_symbol);
      end
   end

   // list is a permutation, so exactly one hit bit is set
   always_comb begin
      pos_enc = '0;
      for (int k = 0; k < LIST_SIZE; k++) begin
         pos_enc = pos_enc | (hit_ff[k] ? SYM_W'(k) : '0);
      end
   end

   assign code_inc      = CODE_W'(code_ff + 1'b1);
   assign run_sat       = code_ff[CODE_W-1];
   assign code_all_ones = ((code_ff & code_inc) == '0);
   assign digit_idx     = DIGIT_W'(digits_ff - 1'b1);

   assign out_free = !out_valid_ff || rsp_ready;
   assign emit_any = cmd.emit_digit || cmd.emit_pos || cmd.emit_eob;

   assign status.front_hit   = hit_ff[0];
   assign status.eob         = eob_ff;
   assign status.run_pending = (digits_ff != '0);
   assign status.last_digit  = (digits_ff == DIGIT_W'(1));
   assign status.out_free    = out_free;

   // output valid flag, run counter and the list (which resets per block)
   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff      <= CODE_W'(1);
         digits_ff    <= '0;
         out_valid_ff <= 1'b0;
         for (int k = 0; k < LIST_SIZE; k++) begin
            list_ff[k] <= SYM_W'(k);
         end
      end else begin
         if (cmd.run_incr && !run_sat) begin
            code_ff <= code_inc;
            if (code_all_ones) digits_ff <= DIGIT_W'(digits_ff + 1'b1);
         end
         if (cmd.emit_digit) begin
            digits_ff <= digit_idx;
            if (digits_ff == DIGIT_W'(1)) code_ff <= CODE_W'(1);
         end
         if (cmd.emit_pos) begin
            for (int k = 1; k < LIST_SIZE; k++) begin
               if (SYM_W'(k) <= pos_ff) list_ff[k] <= list_ff[k-1];
            end
            list_ff[0] <= sym_ff;
         end
         if (cmd.emit_eob) begin
            code_ff   <= CODE_W'(1);
            digits_ff <= '0;
            for (int k = 0; k < LIST_SIZE; k++) begin
               list_ff[k] <= SYM_W'(k);
            end
         end
         if (emit_any) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         sym_ff <= req_symbol;
         eob_ff <= req_end_of_block;
         hit_ff <= hit_in;
      end
      if (cmd.find_pos) pos_ff <= pos_enc;
      if (cmd.emit_digit) begin
         kind_ff     <= code_ff[digit_idx] ? KIND_RUN_A : KIND_RUN_B;
         out_pos_ff  <= '0;
         out_last_ff <= 1'b0;
      end else if (cmd.emit_pos) begin
         kind_ff     <= KIND_POS;
         out_pos_ff  <= pos_ff;
         out_last_ff <= !eob_ff;
      end else if (cmd.emit_eob) begin
         kind_ff     <= KIND_EOB;
         out_pos_ff  <= '0;
         out_last_ff <= 1'b1;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_code_kind   = kind_ff;
   assign rsp_position    = out_pos_ff;
   assign rsp_last_of_run = out_last_ff;

endmodule
`default_nettype wire

// ----- rtl/core/mzr_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mzr_checker
// Port-level checks of the encoder, bound to the top level.
// ----------------------------------------------------------------------------
module mzr_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [1:0]                rsp_code_kind,
   input logic [mzr_pkg::SYM_W-1:0] rsp_position,
   input logic                      rsp_last_of_run
);
   import mzr_pkg::*;

   // one item at a time: the sequencer is busy right after a transfer
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted while previous item in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_code_kind)
         && $stable(rsp_position) && $stable(rsp_last_of_run))
      else $error("stalled result changed");

   a_pos_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_code_kind == KIND_POS |-> rsp_position != '0)
      else $error("position result at front of list");

   a_digit_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_code_kind == KIND_RUN_A || rsp_code_kind == KIND_RUN_B)
         |-> !rsp_last_of_run && rsp_position == '0)
      else $error("run digit marked last or carries a position");

   a_eob_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_code_kind == KIND_EOB |-> rsp_last_of_run && rsp_position == '0)
      else $error("end-of-block code not last");

endmodule

bind mtf_zero_run_encoder mzr_checker u_mzr_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req.valid),
   .req_ready       (req.ready),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_code_kind   (rsp.code_kind),
   .rsp_position    (rsp.position),
   .rsp_last_of_run (rsp.last_of_run)
);
`default_nettype wire
